@@ src/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// shared types and codes of the scope capture and trigger core
// ----------------------------------------------------------------------------
package sct_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ARM    = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_ROLL  = 2'd0,
    MODE_OVER  = 2'd1,
    MODE_TRIG  = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_LTR    = 3'd1,
    REG_TTRACE = 3'd2,
    REG_LEVEL  = 3'd3,
    REG_RISING = 3'd4,
    REG_SINGLE = 3'd5,
    REG_POINTS = 3'd6,
    REG_BATCH  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DECIDE,
    ST_RD_WAIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_STG_RD,
    ST_STG_WR,
    ST_DONE,
    ST_OUT
  } state_t;

  localparam int MIN_POINTS = 10;

endpackage

@@ src/scope_capture_trigger_core.sv @@
// ----------------------------------------------------------------------------
// scope_capture_trigger_core
// multi-trace scope capture with roll, overwrite, trigger and hold modes
// ----------------------------------------------------------------------------
// channel  dir  fields
// in_      in   tuser: opcode; tdata: trace, sample, read_index
// out_     out  tdata: read_value, write_position, searching, trigger_fired,
//                      roll_flushed
// cfg_     in   write enable, register index, data
// after reset the display memory is cleared, one entry a cycle, through every
// entry of every trace, before the first word is accepted
// a word passes through decide, done and out, plus a read wait for a read
// inside the display; a roll flush moves each point in use through a display
// memory read/write pair, kept points shifted before staged ones are copied in
// in_tready is low from acceptance until the result word is taken
// ----------------------------------------------------------------------------
module scope_capture_trigger_core #(
  parameter int TRACES      = 8,
  parameter int POINTS      = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  // trace, sample, read_index, zero fill
  input  logic [((3+SAMPLE_BITS+10+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value, write_position[9:0], searching, trigger_fired, roll_flushed
  output logic [((SAMPLE_BITS+13+7)/8)*8-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sct_pkg::*;

  localparam int TB  = (TRACES > 1) ? $clog2(TRACES) : 1;
  localparam int PB  = $clog2(POINTS);
  localparam int AB  = TB + PB;
  localparam int DEPTH = TRACES * POINTS;
  localparam int OW  = ((SAMPLE_BITS+13+7)/8)*8;
  localparam int NB  = PB + 1;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // configuration
  logic [1:0]  mode_r;
  logic        ltr_r, rising_r, single_r;
  logic [2:0]  ttrace_r;
  logic signed [15:0] level_r;
  logic [10:0] points_r;
  logic [9:0]  batch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ROLL; ltr_r <= 1'b0; ttrace_r <= '0; level_r <= '0;
      rising_r <= 1'b1; single_r <= 1'b0; points_r <= 11'd100; batch_r <= 10'd3;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:   mode_r   <= cfg_data[1:0];
        REG_LTR:    ltr_r    <= cfg_data[0];
        REG_TTRACE: ttrace_r <= cfg_data[2:0];
        REG_LEVEL:  level_r  <= cfg_data;
        REG_RISING: rising_r <= cfg_data[0];
        REG_SINGLE: single_r <= cfg_data[0];
        REG_POINTS: points_r <= cfg_data[10:0];
        REG_BATCH:  batch_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // saturated point count
  logic [NB-1:0] n_w;
  always_comb begin
    if (points_r < 11'(MIN_POINTS)) n_w = NB'(MIN_POINTS);
    else if ({21'd0, points_r} > 32'(POINTS)) n_w = NB'(POINTS);
    else n_w = NB'(points_r);
  end

  // memories
  smp_t disp_mem [DEPTH];
  smp_t stg_mem  [DEPTH];
  logic          d_we, s_we;
  logic [AB-1:0] d_wa, d_ra, s_wa, s_ra;
  smp_t          d_wd, s_wd, d_rd_r, s_rd_r;

  always_ff @(posedge clk) begin
    if (d_we) disp_mem[d_wa] <= d_wd;
    d_rd_r <= disp_mem[d_ra];
  end
  always_ff @(posedge clk) begin
    if (s_we) stg_mem[s_wa] <= s_wd;
    s_rd_r <= stg_mem[s_ra];
  end

  // state
  state_t state_r, state_nxt;
  logic [9:0] pos_r [TRACES];
  logic [9:0] pos_nxt [TRACES];
  logic search_r, search_nxt, armed_r, armed_nxt;
  smp_t prev_r, prev_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [2:0]  tr_r, tr_nxt;
  smp_t        smp_r, smp_nxt;
  logic [9:0]  ri_r, ri_nxt;
  logic [AB-1:0] clr_r, clr_nxt;
  logic [NB-1:0] i_r, i_nxt, b_r, b_nxt;
  smp_t rv_r, rv_nxt;
  logic fired_r, fired_nxt, flush_r, flush_nxt;
  logic [9:0] wp_r, wp_nxt;

  logic valid_t;
  logic [TB-1:0] ti;
  logic [NB-1:0] p_w, lim_w;
  logic [AB-1:0] base;

  assign valid_t = {29'd0, tr_r} < 32'(TRACES);
  assign ti      = TB'(tr_r);
  assign base    = AB'(ti) << PB;
  assign p_w     = ({1'b0, pos_r[ti]} >= n_w) ? NB'(0) : NB'(pos_r[ti]);
  assign lim_w   = ({1'b0, batch_r} > (n_w - NB'(1))) ? n_w - NB'(1) : NB'(batch_r);

  always_comb begin
    logic hit;
    logic [NB-1:0] np;
    state_nxt = state_r; search_nxt = search_r; armed_nxt = armed_r; prev_nxt = prev_r;
    op_nxt = op_r; tr_nxt = tr_r; smp_nxt = smp_r; ri_nxt = ri_r; clr_nxt = clr_r;
    i_nxt = i_r; b_nxt = b_r; rv_nxt = rv_r; fired_nxt = fired_r; flush_nxt = flush_r;
    wp_nxt = wp_r;
    for (int k = 0; k < TRACES; k++) pos_nxt[k] = pos_r[k];
    d_we = 1'b0; d_wa = base; d_wd = smp_r; d_ra = base;
    s_we = 1'b0; s_wa = base; s_wd = smp_r; s_ra = base;
    hit = 1'b0; np = '0;
    in_tready = 1'b0; out_tvalid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        d_we = 1'b1; d_wa = clr_r; d_wd = '0;
        clr_nxt = clr_r + AB'(1);
        if (clr_r == AB'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt = in_tuser; tr_nxt = in_tdata[2:0];
          smp_nxt = in_tdata[3 +: SAMPLE_BITS];
          ri_nxt = in_tdata[3+SAMPLE_BITS +: 10];
          rv_nxt = '0; fired_nxt = 1'b0; flush_nxt = 1'b0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        case (opcode_t'(op_r))
          OP_ARM: armed_nxt = 1'b1;
          OP_READ: begin
            d_ra = base | AB'(ri_r);
            if (valid_t && {1'b0, ri_r} < n_w && 32'(ri_r) < 32'(POINTS))
              state_nxt = ST_RD_WAIT;
          end
          OP_SAMPLE: if (valid_t) begin
            case (mode_t'(mode_r))
              MODE_ROLL: begin
                s_we = 1'b1; s_wa = base | AB'(p_w);
                np = p_w + NB'(1);
                if (np > lim_w) begin
                  b_nxt = np; flush_nxt = 1'b1; pos_nxt[ti] = '0;
                  if (ltr_r) i_nxt = n_w - NB'(1); else i_nxt = '0;
                  state_nxt = ST_SHIFT_RD;
                  if (np >= n_w) begin
                    i_nxt = '0;
                    state_nxt = ST_STG_RD;
                  end
                end else pos_nxt[ti] = 10'(np);
              end
              MODE_OVER: begin
                d_we = 1'b1; d_wa = base | AB'(p_w);
                if (ltr_r) pos_nxt[ti] = (p_w + NB'(1) > n_w - NB'(1)) ? '0 : 10'(p_w + NB'(1));
                else pos_nxt[ti] = (p_w == '0) ? 10'(n_w - NB'(1)) : 10'(p_w - NB'(1));
              end
              MODE_TRIG: begin
                if (search_r) begin
                  if (tr_r == ttrace_r) begin
                    if (!(single_r && !armed_r)) begin
                      hit = rising_r ? (smp_r > level_r && prev_r < level_r)
                                     : (smp_r < level_r && prev_r > level_r);
                      if (hit) begin
                        search_nxt = 1'b0; armed_nxt = 1'b0; fired_nxt = 1'b1;
                        for (int k = 0; k < TRACES; k++)
                          pos_nxt[k] = ltr_r ? '0 : 10'(n_w - NB'(1));
                      end
                    end
                    prev_nxt = smp_r;
                  end else if (p_w > '0 && p_w < n_w - NB'(1)) begin
                    d_we = 1'b1; d_wa = base | AB'(p_w);
                    pos_nxt[ti] = ltr_r ? 10'(p_w + NB'(1)) : 10'(p_w - NB'(1));
                  end
                end else begin
                  d_we = 1'b1; d_wa = base | AB'(p_w);
                  if (ltr_r) begin
                    if (p_w + NB'(1) > n_w - NB'(1)) begin
                      pos_nxt[ti] = '0; hit = 1'b1;
                    end else pos_nxt[ti] = 10'(p_w + NB'(1));
                  end else begin
                    if (p_w == '0) begin
                      pos_nxt[ti] = 10'(n_w - NB'(1)); hit = 1'b1;
                    end else pos_nxt[ti] = 10'(p_w - NB'(1));
                  end
                  if (hit && tr_r == ttrace_r) begin
                    search_nxt = 1'b1; prev_nxt = smp_r;
                  end
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_RD_WAIT: begin
        rv_nxt = d_rd_r; state_nxt = ST_DONE;
      end
      // move kept points by b, one point per read/write pair
      ST_SHIFT_RD: begin
        d_ra = ltr_r ? (base | AB'(i_r - b_r)) : (base | AB'(i_r + b_r));
        state_nxt = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        d_we = 1'b1; d_wa = base | AB'(i_r); d_wd = d_rd_r;
        if (ltr_r) begin
          i_nxt = i_r - NB'(1);
          if (i_r == b_r) begin i_nxt = '0; state_nxt = ST_STG_RD; end
          else state_nxt = ST_SHIFT_RD;
        end else begin
          i_nxt = i_r + NB'(1);
          if (i_r + b_r + NB'(1) >= n_w) begin i_nxt = '0; state_nxt = ST_STG_RD; end
          else state_nxt = ST_SHIFT_RD;
        end
      end
      ST_STG_RD: begin
        s_ra = ltr_r ? (base | AB'(b_r - NB'(1) - i_r)) : (base | AB'(i_r));
        state_nxt = ST_STG_WR;
      end
      ST_STG_WR: begin
        d_we = 1'b1; d_wd = s_rd_r;
        d_wa = ltr_r ? (base | AB'(i_r)) : (base | AB'(n_w - b_r + i_r));
        i_nxt = i_r + NB'(1);
        state_nxt = (i_r + NB'(1) >= b_r) ? ST_DONE : ST_STG_RD;
      end
      ST_DONE: begin
        wp_nxt = valid_t ? pos_r[ti] : '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_r <= '0; search_r <= 1'b1; armed_r <= 1'b1;
      prev_r <= '0;
      for (int k = 0; k < TRACES; k++) pos_r[k] <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; search_r <= search_nxt;
      armed_r <= armed_nxt; prev_r <= prev_nxt;
      for (int k = 0; k < TRACES; k++) pos_r[k] <= pos_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; tr_r <= tr_nxt; smp_r <= smp_nxt; ri_r <= ri_nxt;
    i_r <= i_nxt; b_r <= b_nxt; rv_r <= rv_nxt; fired_r <= fired_nxt;
    flush_r <= flush_nxt; wp_r <= wp_nxt;
  end

  assign out_tdata = OW'({flush_r, fired_r, search_r, wp_r, rv_r});

  // a result never reports both a flush and a trigger
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(flush_r && fired_r)) else $error("flush and trigger together");
  // a trigger leaves the search stopped
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && fired_r) |-> !search_r) else $error("trigger left search on");
  // no word accepted while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready while result pending");

endmodule
